// ===== rtl/drcw_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// drcw_pkg
// Shared types and constants for the display RAM cursor writer.
// ---------------------------------------------------------------------------
package drcw_pkg;

    // Input item kinds carried on s_tuser.
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_CMD  = 2'd1;
    localparam logic [1:0] KIND_EXEC = 2'd2;

    // Command sequence bytes: set column range, then set page range.
    localparam logic [7:0] CMD_SET_COLUMN = 8'h21;
    localparam logic [7:0] CMD_COLUMN_END = 8'h7F;
    localparam logic [7:0] CMD_SET_PAGE   = 8'h22;
    localparam logic [7:0] CMD_PAGE_END   = 8'h07;

    localparam int WINDOW_LEN = 6;
    localparam int TDATA_OUT_W = 32;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_WRITE,
        OP_LOAD
    } drcw_op_kind_t;

    // One classified request handed from the front end to the back end.
    // For OP_WRITE arg_a holds the data byte; for OP_LOAD arg_a is the
    // column and arg_b the page.
    typedef struct packed {
        drcw_op_kind_t kind;
        logic [7:0]    arg_a;
        logic [7:0]    arg_b;
    } drcw_op_t;

endpackage : drcw_pkg
`default_nettype wire

// ===== rtl/drcw_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// drcw_front
// Accepts requests, keeps the command window and classifies each request
// into a write, cursor load or no-op for the back end.
// ---------------------------------------------------------------------------
module drcw_front
    import drcw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,     // [7:0] byte_in
    input  wire logic [1:0] s_tuser,     // [1:0] kind
    input  wire logic       q_full,
    output logic            q_push,
    output drcw_op_t        q_op
);

    // Entry 0 is the oldest command byte, the last entry the newest.
    logic [7:0] window_reg  [WINDOW_LEN];
    logic [7:0] window_next [WINDOW_LEN];
    logic       match;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    assign match = (window_reg[0] == CMD_SET_COLUMN) && (window_reg[2] == CMD_COLUMN_END)
                && (window_reg[3] == CMD_SET_PAGE)   && (window_reg[5] == CMD_PAGE_END);

    always_comb begin
        window_next = window_reg;
        q_op.kind   = OP_NOP;
        q_op.arg_a  = s_tdata;
        q_op.arg_b  = 8'd0;
        unique case (s_tuser)
            KIND_DATA: begin
                q_op.kind = OP_WRITE;
            end
            KIND_CMD: begin
                for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                    window_next[i] = window_reg[i + 1];
                end
                window_next[WINDOW_LEN - 1] = s_tdata;
            end
            KIND_EXEC: begin
                if (match) begin
                    q_op.kind  = OP_LOAD;
                    q_op.arg_a = window_reg[1];
                    q_op.arg_b = window_reg[4];
                end
                window_next[0] = 8'd0;
            end
            default: begin
                q_op.kind = OP_NOP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                window_reg[i] <= 8'd0;
            end
        end else if (q_push) begin
            window_reg <= window_next;
        end
    end

endmodule : drcw_front
`default_nettype wire

// ===== rtl/drcw_fifo.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// drcw_fifo
// Two-entry queue of classified requests between front and back end.
// ---------------------------------------------------------------------------
module drcw_fifo
    import drcw_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  drcw_op_t      push_op,
    input  wire logic     pop,
    output logic          full,
    output logic          empty,
    output drcw_op_t      head_op
);

    drcw_op_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign head_op = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule : drcw_fifo
`default_nettype wire

// ===== rtl/drcw_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// drcw_back
// Holds the page/column cursor, carries out queued requests and drives the
// registered result channel.
// ---------------------------------------------------------------------------
module drcw_back
    import drcw_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   q_empty,
    input  drcw_op_t                    q_op,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [TDATA_OUT_W-1:0]      m_tdata
);

    localparam logic [8:0] COLUMNS_W = 9'(COLUMNS);
    localparam logic [8:0] PAGES_W   = 9'(PAGES);

    logic [7:0] column_reg, column_next;
    logic [7:0] page_reg,   page_next;
    logic       valid_reg;
    logic       we_reg,     we_next;
    logic [2:0] wpage_reg,  wpage_next;
    logic [6:0] wcol_reg,   wcol_next;
    logic [7:0] wbyte_reg,  wbyte_next;

    logic [7:0] col_fix;
    logic [7:0] page_step;
    logic [7:0] page_fix;
    logic [8:0] col_inc;

    assign q_pop = !q_empty && (!valid_reg || m_tready);

    // Resolve an out-of-range cursor before the write, then advance it.
    always_comb begin
        if ({1'b0, column_reg} >= COLUMNS_W) begin
            col_fix   = 8'd0;
            page_step = page_reg + 8'd1;
        end else begin
            col_fix   = column_reg;
            page_step = page_reg;
        end
        page_fix = ({1'b0, page_step} >= PAGES_W) ? 8'd0 : page_step;
        col_inc  = {1'b0, col_fix} + 9'd1;
    end

    always_comb begin
        column_next = column_reg;
        page_next   = page_reg;
        we_next     = 1'b0;
        wpage_next  = 3'd0;
        wcol_next   = 7'd0;
        wbyte_next  = 8'd0;
        case (q_op.kind)
            OP_WRITE: begin
                we_next    = 1'b1;
                wpage_next = page_fix[2:0];
                wcol_next  = col_fix[6:0];
                wbyte_next = q_op.arg_a;
                if (col_inc >= COLUMNS_W) begin
                    column_next = 8'd0;
                    page_next   = page_fix + 8'd1;
                end else begin
                    column_next = col_inc[7:0];
                    page_next   = page_fix;
                end
            end
            OP_LOAD: begin
                column_next = q_op.arg_a;
                page_next   = q_op.arg_b;
            end
            default: begin
                we_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= 8'd0;
            page_reg   <= 8'd0;
            valid_reg  <= 1'b0;
        end else begin
            if (q_pop) begin
                column_reg <= column_next;
                page_reg   <= page_next;
                valid_reg  <= 1'b1;
            end else if (m_tready) begin
                valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            we_reg    <= we_next;
            wpage_reg <= wpage_next;
            wcol_reg  <= wcol_next;
            wbyte_reg <= wbyte_next;
        end
    end

    // The serial reply is always zero.
    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, 8'd0, wbyte_reg, wcol_reg, wpage_reg, we_reg};

endmodule : drcw_back
`default_nettype wire

// ===== rtl/display_ram_cursor_writer.sv =====
`default_nettype none
// A request accepted by the front end is written into the two-entry queue;
// the back end pops it when the output is free and registers its result,
// which raises m_tvalid.
// Throughput: one request per cycle unless the output stalls, limited by
// the single cursor update in the back end; a two-entry queue absorbs stalls.
// Reset: aresetn (synchronous, active low) clears cursor, command window,
// queue and output valid.
// ---------------------------------------------------------------------------
// display_ram_cursor_writer
// Receive side of a page-organized display controller: data bytes become
// display memory writes at an advancing cursor, command bytes can reload it.
// ---------------------------------------------------------------------------
module display_ram_cursor_writer
    import drcw_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] write_enable, [3:1] write_page, [10:4] write_column,
    // [18:11] write_byte, [26:19] serial_reply, [31:27] zero
    output logic [31:0]      m_tdata
);

    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;
    drcw_op_t push_op;
    drcw_op_t head_op;

    drcw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (push_op)
    );

    drcw_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_op  (push_op),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_op  (head_op)
    );

    drcw_back #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_op     (head_op),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule : display_ram_cursor_writer
`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Display RAM cursor writer testbench
// Drives tagged serial bytes into the request stream and checks every memory
// write result against a cycle-free model of the cursor and command window.
// Directed tests cover the cursor wrap, set-cursor sequences and the unused
// kind; random traffic mixes well-formed and broken sequences with data runs.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import drcw_pkg::*;

    localparam int COLUMNS = 128;
    localparam int PAGES   = 8;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 650;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 10;

    // Result layout, write_enable in bit 0.
    typedef struct packed {
        logic [4:0] pad;
        logic [7:0] reply;
        logic [7:0] wbyte;
        logic [6:0] column;
        logic [2:0] page;
        logic       we;
    } mem_write_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire logic   s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [1:0]  s_tuser = 2'd0;
    wire logic   m_tvalid;
    logic        m_tready = 1'b0;
    wire logic [31:0] m_tdata;

    // Model state.
    logic [7:0] cur_column = 8'd0;
    logic [7:0] cur_page = 8'd0;
    logic [7:0] cmd_window [0:WINDOW_LEN-1] = '{default: 8'h00};

    mem_write_t expected_writes [$];
    mem_write_t want_write;
    mem_write_t got_write;
    int  fail_count = 0;
    int  idle_cycles = 0;
    bit  steady = 1'b0;

    display_ram_cursor_writer #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Computes the memory write caused by one request and advances the model.
    function automatic mem_write_t predict_mem_write(input logic [1:0] kind,
                                                     input logic [7:0] data_byte);
        mem_write_t res;
        int next_col;
        res = '0;
        case (kind)
            KIND_DATA: begin
                // A loaded cursor may sit outside the display; fold it first.
                if (int'(cur_column) >= COLUMNS) begin
                    cur_page = cur_page + 8'd1;
                    cur_column = 8'd0;
                end
                if (int'(cur_page) >= PAGES)
                    cur_page = 8'd0;
                res.we = 1'b1;
                res.page = cur_page[2:0];
                res.column = cur_column[6:0];
                res.wbyte = data_byte;
                next_col = int'(cur_column) + 1;
                if (next_col >= COLUMNS) begin
                    cur_column = 8'd0;
                    cur_page = cur_page + 8'd1;
                end else begin
                    cur_column = next_col[7:0];
                end
            end
            KIND_CMD: begin
                for (int i = 0; i < WINDOW_LEN - 1; i++)
                    cmd_window[i] = cmd_window[i + 1];
                cmd_window[WINDOW_LEN - 1] = data_byte;
            end
            KIND_EXEC: begin
                if (cmd_window[0] == CMD_SET_COLUMN && cmd_window[2] == CMD_COLUMN_END &&
                    cmd_window[3] == CMD_SET_PAGE && cmd_window[5] == CMD_PAGE_END) begin
                    cur_column = cmd_window[1];
                    cur_page = cmd_window[4];
                end
                cmd_window[0] = 8'h00;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Sends one request; valid stays high across back-to-back requests.
    task automatic send_request(input logic [1:0] kind, input logic [7:0] data_byte);
        while (!steady && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= data_byte;
        do
            @(posedge aclk);
        while (!s_tready);
        expected_writes.push_back(predict_mem_write(kind, data_byte));
    endtask

    task automatic send_set_cursor(input logic [7:0] col, input logic [7:0] page);
        send_request(KIND_CMD, CMD_SET_COLUMN);
        send_request(KIND_CMD, col);
        send_request(KIND_CMD, CMD_COLUMN_END);
        send_request(KIND_CMD, CMD_SET_PAGE);
        send_request(KIND_CMD, page);
        send_request(KIND_CMD, CMD_PAGE_END);
    endtask

    task automatic test_directed_writes();
        send_request(KIND_DATA, 8'h00);
        send_request(KIND_DATA, 8'hFF);
        send_request(KIND_UNUSED, 8'hFF);
    endtask

    // Last column of the last page, so the second write wraps to page 0.
    task automatic test_cursor_load();
        send_set_cursor(8'h7F, 8'h07);
        send_request(KIND_EXEC, 8'hFF);
        send_request(KIND_DATA, 8'hA5);
        send_request(KIND_DATA, 8'h5A);
    endtask

    // Column and page both past the end; the execute that follows finds the
    // oldest window byte cleared and must not load again.
    task automatic test_out_of_range_load();
        send_set_cursor(8'hC8, 8'hFF);
        send_request(KIND_EXEC, 8'h00);
        send_request(KIND_DATA, 8'h3C);
        send_request(KIND_EXEC, 8'h80);
    endtask

    task automatic test_random_traffic();
        int sent;
        int pick;
        int run_len;
        logic [7:0] col;
        logic [7:0] page;
        logic [7:0] seq [0:5];
        int spot;
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            steady = (sent >= 250 && sent < 400);
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                case ($urandom_range(0, 3))
                    0: col = 8'($urandom_range(0, 255));
                    1: col = 8'($urandom_range(120, 127));
                    default: col = 8'($urandom_range(0, 127));
                endcase
                page = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 7));
                seq = '{CMD_SET_COLUMN, col, CMD_COLUMN_END, CMD_SET_PAGE, page,
                        CMD_PAGE_END};
                // About one sequence in five gets a broken marker byte.
                if ($urandom_range(0, 4) == 0) begin
                    case ($urandom_range(0, 3))
                        0: spot = 0;
                        1: spot = 2;
                        2: spot = 3;
                        default: spot = 5;
                    endcase
                    seq[spot] = seq[spot] ^ 8'($urandom_range(1, 255));
                end
                for (int i = 0; i < 6; i++)
                    send_request(KIND_CMD, seq[i]);
                send_request(KIND_EXEC, 8'($urandom_range(0, 255)));
                sent += 7;
            end else if (pick < 75) begin
                run_len = $urandom_range(1, 40);
                for (int i = 0; i < run_len; i++)
                    send_request(KIND_DATA, 8'($urandom_range(0, 255)));
                sent += run_len;
            end else if (pick < 88) begin
                send_request(KIND_CMD, 8'($urandom_range(0, 255)));
                sent++;
            end else if (pick < 96) begin
                send_request(KIND_EXEC, 8'($urandom_range(0, 255)));
                sent++;
            end else begin
                send_request(KIND_UNUSED, 8'($urandom_range(0, 255)));
                sent++;
            end
        end
        steady = 1'b0;
    endtask

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 9);
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_write = m_tdata;
            if (expected_writes.size() == 0) begin
                $error("result 0x%08h with no request waiting", m_tdata);
                fail_count++;
            end else begin
                want_write = expected_writes.pop_front();
                check_field("write_enable", want_write.we, got_write.we);
                check_field("write_page", want_write.page, got_write.page);
                check_field("write_column", want_write.column, got_write.column);
                check_field("write_byte", want_write.wbyte, got_write.wbyte);
                check_field("serial_reply", want_write.reply, got_write.reply);
                check_field("tdata_pad", want_write.pad, got_write.pad);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[display_ram_cursor_writer] ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_writes();
        test_cursor_load();
        test_out_of_range_load();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[display_ram_cursor_writer] OK");
        else
            $display("[display_ram_cursor_writer] ERROR");
        $finish;
    end

endmodule : tb_top
